// File: rtl/core/oxygen_reading_scale_and_average_assert.svh
// Assertion macros for the oxygen reading scale and average block.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef OXYGEN_READING_SCALE_AND_AVERAGE_ASSERT_SVH
`define OXYGEN_READING_SCALE_AND_AVERAGE_ASSERT_SVH

// Condition holds in the same cycle.
`define ORAS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition holds in the following cycle.
`define ORAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/oras_pkg.sv
// Shared types and constants for the oxygen reading scale and average block.
// No dependencies.
`timescale 1ns / 1ps

package oras_pkg;

	localparam int BYTE_W     = 8;
	localparam int SAMPLE_W   = 13;
	localparam int RAW_W      = 15;
	localparam int PROD_W     = 23;
	localparam int DVS_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam int WLEN_W     = 4;
	localparam int RECIP_W    = 24;
	localparam int RECIP_SH   = 33;

	localparam logic [CFG_IDX_W-1:0] REG_KEY  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WLEN = 1'd1;

	localparam logic [BYTE_W-1:0] KEY_RESET  = 8'd0;
	localparam logic [WLEN_W-1:0] WLEN_RESET = 4'd10;

	localparam logic [BYTE_W-1:0] DEF_MUL = 8'd209;
	localparam logic [DVS_W-1:0]  DEF_DIV = 11'd1200;
	localparam logic [DVS_W-1:0]  KEY_DIV = 11'd1000;

	// ceil(2^33 / 1000) and ceil(2^33 / 1200), exact for every product in range
	localparam logic [RECIP_W-1:0] KEY_RECIP = 24'd8589935;
	localparam logic [RECIP_W-1:0] DEF_RECIP = 24'd7158279;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SDIV,
		ST_SHIFT,
		ST_SUM,
		ST_MDIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: rtl/core/oras_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module oras_ram #(
	parameter int W = 13,
	parameter int D = 10,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/oras_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, quotient known to fit Q_W bits.
// Depends on oras_pkg.
`timescale 1ns / 1ps

module oras_div #(
	parameter int DVD_W = 23,
	parameter int DVS_W = 11,
	parameter int Q_W   = 13
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DVD_W-1:0]    dividend,
	input  logic [DVS_W-1:0]    divisor,
	output logic [Q_W-1:0]      quotient,
	output oras_pkg::div_stat_t stat
);

	import oras_pkg::*;

	localparam int CW = $clog2(Q_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [Q_W-1:0]   quo_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;
	logic [DVS_W-1:0] rem_nxt;

	assign trial   = {rem_q, quo_q[Q_W-1]};
	assign ge      = (trial >= {1'b0, dvs_q});
	assign diff    = trial - {1'b0, dvs_q};
	assign rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DVS_W'(dividend >> Q_W);
			quo_q <= dividend[Q_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: rtl/core/oxygen_reading_scale_and_average.sv
// Oxygen reading scale and average: each transfer in carries three raw sensor bytes
// (whole, tenths, hundredths). The block forms raw = 100*whole + 10*tenths + hundredths,
// scales it to hundredths of a percent with the calibration key (key*raw/1000, or
// raw*209/1200 when the key is zero), shifts the sample into a window held in a
// synchronous RAM and returns the truncated mean of the filled entries together with
// the sample itself. One item is in work at a time, and the next transfer in is taken
// in the cycle after the result is loaded. Each item passes in order through the
// scaling by reciprocal multiplication (states MUL and SDIV), the one-entry-per-cycle
// sweeps through the window RAM (shift, then sum) and the 13-step mean divide.
// The next item is taken while a finished result still waits in the output register.
// Depends on oras_pkg, oras_ram, oras_div and the assertion macro header.
`timescale 1ns / 1ps

module oxygen_reading_scale_and_average #(
	parameter int WINDOW_DEPTH = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// whole_byte [7:0], tenths_byte [15:8], hundredths_byte [23:16]
	input  logic [23:0]                     s_axis_tdata,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// mean_level [12:0], current_sample [25:13], zero [31:26]
	output logic [31:0]                     m_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic                            cfg_we,
	input  logic [oras_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [oras_pkg::CFG_DATA_W-1:0] cfg_data
);

	import oras_pkg::*;

	localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int LW    = (CNT_W > WLEN_W) ? CNT_W : WLEN_W;
	localparam int SUM_W = $clog2(WINDOW_DEPTH * ((1 << SAMPLE_W) - 1) + 1);
	localparam int SCL_W = PROD_W + RECIP_W;

	state_t state_q, state_nxt;

	logic [BYTE_W-1:0]   key_q;
	logic [WLEN_W-1:0]   wlen_q;
	logic [BYTE_W-1:0]   whole_q, tenths_q, hund_q;
	logic [PROD_W-1:0]   prod_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [CNT_W-1:0]    filled_q;
	logic [CNT_W-1:0]    ptr_q;
	logic [CNT_W-1:0]    ptr_dec;
	logic                pend_s1;
	logic [AW-1:0]       waddr_s1;
	logic [SUM_W-1:0]    acc_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] mean_q;

	logic [CNT_W-1:0]    eff_len;
	logic [LW-1:0]       wlen_ext;
	logic [RAW_W-1:0]    raw;
	logic [BYTE_W-1:0]   mul_a;
	logic [PROD_W-1:0]   prod;
	logic [RECIP_W-1:0]  recip;
	logic [SCL_W-1:0]    scaled;

	logic                in_fire, out_load;
	logic                shift_issue, shift_last, sum_issue, sum_last;
	logic                div_start;
	logic [SAMPLE_W-1:0] div_quot;
	div_stat_t           div_stat;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr, ram_raddr;
	logic [SAMPLE_W-1:0] ram_wdata, ram_rdata;

	// Effective window length: zero counts as one, clamp to depth.
	assign wlen_ext = LW'(wlen_q);
	always_comb begin
		if (wlen_q == '0) begin
			eff_len = CNT_W'(1);
		end else if (wlen_ext > LW'(WINDOW_DEPTH)) begin
			eff_len = CNT_W'(WINDOW_DEPTH);
		end else begin
			eff_len = CNT_W'(wlen_q);
		end
	end

	assign raw = RAW_W'(whole_q) * RAW_W'(100) + RAW_W'(tenths_q) * RAW_W'(10)
		+ RAW_W'(hund_q);
	assign mul_a = (key_q != '0) ? key_q : DEF_MUL;
	assign prod  = PROD_W'(mul_a) * PROD_W'(raw);
	assign recip  = (key_q != '0) ? KEY_RECIP : DEF_RECIP;
	assign scaled = SCL_W'(prod_q) * SCL_W'(recip);
	assign ptr_dec = ptr_q - 1'b1;

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_fire) state_nxt = ST_MUL;
			ST_MUL:   state_nxt = ST_SDIV;
			ST_SDIV:  state_nxt = ST_SHIFT;
			ST_SHIFT: if (shift_last) state_nxt = ST_SUM;
			ST_SUM:   if (sum_last) state_nxt = ST_MDIV;
			ST_MDIV:  if (div_stat.done) state_nxt = ST_DONE;
			ST_DONE:  if (out_load) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		s_axis_tready = 1'b0;
		shift_issue   = 1'b0;
		shift_last    = 1'b0;
		sum_issue     = 1'b0;
		sum_last      = 1'b0;
		out_load      = 1'b0;
		div_start     = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = waddr_s1;
		ram_wdata     = ram_rdata;
		ram_raddr     = ptr_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_SHIFT: begin
				ram_raddr   = ptr_dec[AW-1:0];
				shift_issue = (ptr_q != '0);
				shift_last  = (ptr_q == '0) && !pend_s1;
				if (pend_s1) begin
					ram_we = 1'b1;
				end else if (shift_last) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = sample_q;
				end
			end
			ST_SUM: begin
				sum_issue = (ptr_q != filled_q);
				sum_last  = (ptr_q == filled_q) && !pend_s1;
				if (sum_last) begin
					div_start = 1'b1;
				end
			end
			ST_DONE: begin
				out_load = !out_valid_q || m_axis_tready;
			end
			default: begin
			end
		endcase
	end

	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			key_q       <= KEY_RESET;
			wlen_q      <= WLEN_RESET;
			filled_q    <= '0;
			ptr_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_KEY:  key_q  <= cfg_data;
					REG_WLEN: wlen_q <= cfg_data[WLEN_W-1:0];
					default: begin
					end
				endcase
			end
			pend_s1 <= shift_issue || sum_issue;
			if (state_q == ST_SDIV) begin
				ptr_q <= eff_len - 1'b1;
			end else if (shift_issue) begin
				ptr_q <= ptr_dec;
			end else if (shift_last) begin
				ptr_q <= '0;
				if (filled_q < eff_len) begin
					filled_q <= filled_q + 1'b1;
				end
			end else if (sum_issue) begin
				ptr_q <= ptr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			whole_q  <= s_axis_tdata[7:0];
			tenths_q <= s_axis_tdata[15:8];
			hund_q   <= s_axis_tdata[23:16];
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod;
		end
		if (state_q == ST_SDIV) begin
			sample_q <= scaled[RECIP_SH +: SAMPLE_W];
		end
		if (shift_issue) begin
			waddr_s1 <= ptr_q[AW-1:0];
		end
		if (shift_last) begin
			acc_q <= '0;
		end else if (state_q == ST_SUM && pend_s1) begin
			acc_q <= acc_q + SUM_W'(ram_rdata);
		end
		if (state_q == ST_MDIV && div_stat.done) begin
			mean_q <= div_quot;
		end
		if (out_load) begin
			m_axis_tdata <= {6'd0, sample_q, mean_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;

	oras_ram #(
		.W(SAMPLE_W),
		.D(WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	oras_div #(
		.DVD_W(SUM_W),
		.DVS_W(CNT_W),
		.Q_W  (SAMPLE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q),
		.divisor  (filled_q),
		.quotient (div_quot),
		.stat     (div_stat)
	);

	`include "oxygen_reading_scale_and_average_assert.svh"

	`ORAS_ASSERT_SAME(a_start_idle_div, div_start, !div_stat.busy, "divider restarted while busy")
	`ORAS_ASSERT_SAME(a_sum_count, state_q == ST_SUM, filled_q != '0, "mean over empty window")
	`ORAS_ASSERT_SAME(a_fill_bound, 1'b1, filled_q <= CNT_W'(WINDOW_DEPTH), "fill count past depth")
	`ORAS_ASSERT_NEXT(a_done_hold, state_q == ST_DONE && out_valid_q && !m_axis_tready,
		state_q == ST_DONE, "result dropped while output stalled")

endmodule
